// ----- sv/mfd_pkg.sv -----
// Package with the shared types, codes and constants of the media frame deframer.
package mfd_pkg;

    localparam int LENGTH_BITS_DEF = 21;
    localparam int HDR_BYTES = 16;
    localparam int FILL_W = $clog2(HDR_BYTES);
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W = 21;
    localparam int MAX_LENGTH_W = 21;
    localparam int RESYNC_W = 16;
    localparam int TIMESTAMP_W = 64;
    localparam int HDR_LENGTH_W = 32;
    localparam logic [MAX_LENGTH_W-1:0] MAX_LENGTH_RESET = 21'd4096;

    localparam logic [CFG_INDEX_W-1:0] REG_MAGIC_FIRST = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAGIC_SECOND = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FORMAT_VERSION = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LENGTH = 4'd3;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_TOO_LARGE = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] magic_first;
        logic [7:0] magic_second;
        logic [7:0] format_version;
        logic [MAX_LENGTH_W-1:0] max_length;
    } t_cfg;

    typedef struct packed {
        logic has_result;
        t_kind kind;
        logic last;
    } t_res_ctrl;

endpackage

// ----- sv/mfd_if.sv -----
// Channel interfaces of the media frame deframer: received bytes, configuration and results.
interface mfd_byte_if;
    logic valid;
    logic ready;
    logic [7:0] rx_byte;

    modport source(output valid, output rx_byte, input ready);
    modport sink(input valid, input rx_byte, output ready);
endinterface

interface mfd_cfg_if;
    logic valid;
    logic ready;
    logic [mfd_pkg::CFG_INDEX_W-1:0] index;
    logic [mfd_pkg::CFG_DATA_W-1:0] data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

interface mfd_result_if #(
    parameter int LENGTH_BITS = mfd_pkg::LENGTH_BITS_DEF
);
    logic valid;
    logic ready;
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic [LENGTH_BITS-1:0] frame_length;
    logic [mfd_pkg::TIMESTAMP_W-1:0] timestamp;
    logic [7:0] frame_flags;
    logic last;
    logic [mfd_pkg::RESYNC_W-1:0] resync_total;

    modport source(
        output valid, output kind, output payload_byte, output frame_length,
        output timestamp, output frame_flags, output last, output resync_total,
        input ready
    );
    modport sink(
        input valid, input kind, input payload_byte, input frame_length,
        input timestamp, input frame_flags, input last, input resync_total,
        output ready
    );
endinterface

// ----- sv/media_frame_deframer_top.sv -----
// Top level of the media frame deframer: byte input, configuration writes and frame results.
//
// Received bytes enter on i_rx, one per transaction. The block hunts for a 16-byte header
// (two magic bytes, version, flags, 32-bit length, 64-bit timestamp, all little-endian) and
// then passes the payload bytes through on o_res, the final one marked last. A header with
// a length above max_length gives a single too-large result instead.
// Configuration writes arrive on i_cfg, register index and data per transaction, and are
// always accepted; they are meant to be written while the block is idle.
// A taken byte waits in the input register, where the header and payload logic reads it;
// its result, if any, is loaded into the result register when that register can advance.
// One byte per cycle is sustained while o_res.ready stays high, set by the input register
// and result register pair with the header and payload logic between them.
// Reset clears the header fill, the payload count, the resync counter and both stages, and
// loads the register reset values. When the receiver stalls, the result register holds its
// result, the input register keeps its byte or takes one if empty, and i_rx.ready goes low.
module media_frame_deframer_top #(
    parameter int LENGTH_BITS = mfd_pkg::LENGTH_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mfd_byte_if.sink     i_rx,
    mfd_cfg_if.sink      i_cfg,
    mfd_result_if.source o_res
);

    mfd_pkg::t_cfg                   w_cfg;
    mfd_pkg::t_res_ctrl              w_ctrl;
    logic                            w_advance;
    logic                            w_fire;
    logic [7:0]                      w_byte;
    logic [7:0]                      w_payload_byte;
    logic [LENGTH_BITS-1:0]          w_frame_length;
    logic [mfd_pkg::TIMESTAMP_W-1:0] w_timestamp;
    logic [7:0]                      w_frame_flags;
    logic [mfd_pkg::RESYNC_W-1:0]    w_resync_total;

    assign i_cfg.ready = 1'b1;

    mfd_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (w_cfg)
    );

    mfd_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_rx.valid),
        .i_byte    (i_rx.rx_byte),
        .o_ready   (i_rx.ready),
        .i_advance (w_advance),
        .o_fire    (w_fire),
        .o_byte    (w_byte)
    );

    mfd_hunt #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_hunt (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_fire),
        .i_byte         (w_byte),
        .i_cfg          (w_cfg),
        .o_ctrl         (w_ctrl),
        .o_payload_byte (w_payload_byte),
        .o_frame_length (w_frame_length),
        .o_timestamp    (w_timestamp),
        .o_frame_flags  (w_frame_flags),
        .o_resync_total (w_resync_total)
    );

    mfd_out_stage #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_out_stage (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_fire),
        .i_ctrl         (w_ctrl),
        .i_payload_byte (w_payload_byte),
        .i_frame_length (w_frame_length),
        .i_timestamp    (w_timestamp),
        .i_frame_flags  (w_frame_flags),
        .i_resync_total (w_resync_total),
        .i_ready        (o_res.ready),
        .o_advance      (w_advance),
        .o_valid        (o_res.valid),
        .o_kind         (o_res.kind),
        .o_payload_byte (o_res.payload_byte),
        .o_frame_length (o_res.frame_length),
        .o_timestamp    (o_res.timestamp),
        .o_frame_flags  (o_res.frame_flags),
        .o_last         (o_res.last),
        .o_resync_total (o_res.resync_total)
    );

endmodule

// ----- sv/mfd_cfg_regs.sv -----
// Configuration register file of the media frame deframer.
module mfd_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_en,
    input  logic [mfd_pkg::CFG_INDEX_W-1:0]  i_wr_index,
    input  logic [mfd_pkg::CFG_DATA_W-1:0]   i_wr_data,
    output mfd_pkg::t_cfg                    o_cfg
);

    mfd_pkg::t_cfg r_cfg;
    mfd_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (i_wr_index)
                mfd_pkg::REG_MAGIC_FIRST:    n_cfg.magic_first = i_wr_data[7:0];
                mfd_pkg::REG_MAGIC_SECOND:   n_cfg.magic_second = i_wr_data[7:0];
                mfd_pkg::REG_FORMAT_VERSION: n_cfg.format_version = i_wr_data[7:0];
                mfd_pkg::REG_MAX_LENGTH:
                    n_cfg.max_length = i_wr_data[mfd_pkg::MAX_LENGTH_W-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic_first <= 8'd0;
            r_cfg.magic_second <= 8'd0;
            r_cfg.format_version <= 8'd0;
            r_cfg.max_length <= mfd_pkg::MAX_LENGTH_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- sv/mfd_in_stage.sv -----
// Input register stage that holds one received byte for the header and payload logic.
module mfd_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    output logic       o_ready,
    input  logic       i_advance,
    output logic       o_fire,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_advance;
    assign o_fire = r_valid && i_advance;
    assign o_byte = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

// ----- sv/mfd_hunt.sv -----
// Header collection, resynchronization and payload counting of the media frame deframer.
module mfd_hunt #(
    parameter int LENGTH_BITS = mfd_pkg::LENGTH_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_fire,
    input  logic [7:0]                       i_byte,
    input  mfd_pkg::t_cfg                    i_cfg,
    output mfd_pkg::t_res_ctrl               o_ctrl,
    output logic [7:0]                       o_payload_byte,
    output logic [LENGTH_BITS-1:0]           o_frame_length,
    output logic [mfd_pkg::TIMESTAMP_W-1:0]  o_timestamp,
    output logic [7:0]                       o_frame_flags,
    output logic [mfd_pkg::RESYNC_W-1:0]     o_resync_total
);

    localparam int FillW = mfd_pkg::FILL_W;
    localparam int LenW = mfd_pkg::HDR_LENGTH_W;
    localparam logic [LenW-1:0] LenMask = {LenW{1'b1}} >> (LenW - LENGTH_BITS);
    localparam logic [FillW-1:0] FillLast = FillW'(mfd_pkg::HDR_BYTES - 1);

    logic [7:0]                   r_store [mfd_pkg::HDR_BYTES];
    logic [FillW-1:0]             r_fill;
    logic [FillW-1:0]             n_fill;
    logic [LENGTH_BITS-1:0]       r_payload_left;
    logic [LENGTH_BITS-1:0]       n_payload_left;
    logic [mfd_pkg::RESYNC_W-1:0] r_resync;
    logic [mfd_pkg::RESYNC_W-1:0] n_resync;

    logic [7:0]             w_view [mfd_pkg::HDR_BYTES];
    logic                   w_resync;
    logic                   w_slide;
    logic [LenW-1:0]        w_len;
    logic [LenW-1:0]        w_max;
    logic [LENGTH_BITS-1:0] w_clipped;

    always_comb begin
        for (int i = 0; i < mfd_pkg::HDR_BYTES; i++) begin
            w_view[i] = (r_fill == FillW'(i)) ? i_byte : r_store[i];
        end
    end

    assign w_len = {w_view[7], w_view[6], w_view[5], w_view[4]};
    assign w_max = LenW'(i_cfg.max_length) & LenMask;
    assign w_clipped = (w_len > LenMask) ? LenMask[LENGTH_BITS-1:0] : w_len[LENGTH_BITS-1:0];

    always_comb begin
        n_fill = r_fill;
        n_payload_left = r_payload_left;
        w_resync = 1'b0;
        w_slide = 1'b0;
        o_ctrl.has_result = 1'b0;
        o_ctrl.kind = mfd_pkg::KIND_PAYLOAD;
        o_ctrl.last = 1'b0;
        o_payload_byte = 8'd0;
        o_frame_length = '0;
        o_timestamp = '0;
        o_frame_flags = 8'd0;
        if (r_payload_left != '0) begin
            n_payload_left = r_payload_left - LENGTH_BITS'(1);
            o_ctrl.has_result = 1'b1;
            o_ctrl.kind = mfd_pkg::KIND_PAYLOAD;
            o_ctrl.last = (n_payload_left == '0);
            o_payload_byte = i_byte;
        end else if (w_view[0] != i_cfg.magic_first) begin
            n_fill = '0;
            w_resync = 1'b1;
        end else if (r_fill != '0 && w_view[1] != i_cfg.magic_second) begin
            w_slide = 1'b1;
            n_fill = (w_view[1] == i_cfg.magic_first) ? FillW'(1) : FillW'(0);
            w_resync = 1'b1;
        end else if (r_fill != FillLast) begin
            n_fill = r_fill + FillW'(1);
        end else begin
            n_fill = '0;
            if (w_view[2] != i_cfg.format_version) begin
                w_resync = 1'b1;
            end else if (w_len > w_max) begin
                o_ctrl.has_result = 1'b1;
                o_ctrl.kind = mfd_pkg::KIND_TOO_LARGE;
                o_ctrl.last = 1'b1;
                o_frame_length = w_clipped;
            end else begin
                n_payload_left = w_clipped;
                o_ctrl.has_result = 1'b1;
                o_ctrl.kind = mfd_pkg::KIND_HEADER;
                o_ctrl.last = (w_clipped == '0);
                o_frame_length = w_clipped;
                o_frame_flags = w_view[3];
                o_timestamp = {w_view[15], w_view[14], w_view[13], w_view[12],
                               w_view[11], w_view[10], w_view[9], w_view[8]};
            end
        end
    end

    assign n_resync = (w_resync && r_resync != {mfd_pkg::RESYNC_W{1'b1}})
                    ? r_resync + mfd_pkg::RESYNC_W'(1) : r_resync;
    assign o_resync_total = n_resync;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_payload_left <= '0;
            r_resync <= '0;
        end else if (i_fire) begin
            r_fill <= n_fill;
            r_payload_left <= n_payload_left;
            r_resync <= n_resync;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && r_payload_left == '0) begin
            r_store[r_fill] <= i_byte;
            if (w_slide) begin
                r_store[0] <= w_view[1];
            end
        end
    end

endmodule

// ----- sv/mfd_out_stage.sv -----
// Result register stage that holds one result until the receiver takes it.
module mfd_out_stage #(
    parameter int LENGTH_BITS = mfd_pkg::LENGTH_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_fire,
    input  mfd_pkg::t_res_ctrl               i_ctrl,
    input  logic [7:0]                       i_payload_byte,
    input  logic [LENGTH_BITS-1:0]           i_frame_length,
    input  logic [mfd_pkg::TIMESTAMP_W-1:0]  i_timestamp,
    input  logic [7:0]                       i_frame_flags,
    input  logic [mfd_pkg::RESYNC_W-1:0]     i_resync_total,
    input  logic                             i_ready,
    output logic                             o_advance,
    output logic                             o_valid,
    output logic [1:0]                       o_kind,
    output logic [7:0]                       o_payload_byte,
    output logic [LENGTH_BITS-1:0]           o_frame_length,
    output logic [mfd_pkg::TIMESTAMP_W-1:0]  o_timestamp,
    output logic [7:0]                       o_frame_flags,
    output logic                             o_last,
    output logic [mfd_pkg::RESYNC_W-1:0]     o_resync_total
);

    logic                            r_valid;
    mfd_pkg::t_kind                  r_kind;
    logic [7:0]                      r_payload_byte;
    logic [LENGTH_BITS-1:0]          r_frame_length;
    logic [mfd_pkg::TIMESTAMP_W-1:0] r_timestamp;
    logic [7:0]                      r_frame_flags;
    logic                            r_last;
    logic [mfd_pkg::RESYNC_W-1:0]    r_resync_total;
    logic                            w_load;

    assign o_advance = !r_valid || i_ready;
    assign w_load = o_advance && i_fire && i_ctrl.has_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_fire && i_ctrl.has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_kind <= i_ctrl.kind;
            r_last <= i_ctrl.last;
            r_payload_byte <= i_payload_byte;
            r_frame_length <= i_frame_length;
            r_timestamp <= i_timestamp;
            r_frame_flags <= i_frame_flags;
            r_resync_total <= i_resync_total;
        end
    end

    assign o_valid = r_valid;
    assign o_kind = r_kind;
    assign o_payload_byte = r_payload_byte;
    assign o_frame_length = r_frame_length;
    assign o_timestamp = r_timestamp;
    assign o_frame_flags = r_frame_flags;
    assign o_last = r_last;
    assign o_resync_total = r_resync_total;

endmodule

// ----- sv/mfd_checker.sv -----
// Port-level assertion checker of the media frame deframer and its bind to the top level.
module mfd_checker #(
    parameter int LENGTH_BITS = mfd_pkg::LENGTH_BITS_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [1:0]                      i_kind,
    input logic [7:0]                      i_payload_byte,
    input logic [LENGTH_BITS-1:0]          i_frame_length,
    input logic [mfd_pkg::TIMESTAMP_W-1:0] i_timestamp,
    input logic [7:0]                      i_frame_flags,
    input logic                            i_last,
    input logic [mfd_pkg::RESYNC_W-1:0]    i_resync_total
);

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind)
            && $stable(i_payload_byte) && $stable(i_frame_length)
            && $stable(i_last) && $stable(i_resync_total))
        else $error("Stalled result changed before its transaction.");

    a_too_large_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == mfd_pkg::KIND_TOO_LARGE |-> i_last)
        else $error("Too-large result without last.");

    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == mfd_pkg::KIND_PAYLOAD
            |-> i_frame_length == '0 && i_timestamp == '0 && i_frame_flags == 8'd0)
        else $error("Payload result carries header fields.");

    a_header_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == mfd_pkg::KIND_HEADER |-> i_last == (i_frame_length == '0))
        else $error("Header last does not match a zero length.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result valid right after reset.");

endmodule

bind media_frame_deframer_top mfd_checker #(
    .LENGTH_BITS (LENGTH_BITS)
) u_mfd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_kind         (o_res.kind),
    .i_payload_byte (o_res.payload_byte),
    .i_frame_length (o_res.frame_length),
    .i_timestamp    (o_res.timestamp),
    .i_frame_flags  (o_res.frame_flags),
    .i_last         (o_res.last),
    .i_resync_total (o_res.resync_total)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench of the media frame deframer: directed frames, then random byte streams.
`timescale 1ns / 100ps

module tb_top;

    localparam int LEN_W = mfd_pkg::LENGTH_BITS_DEF;
    localparam logic [LEN_W-1:0] LEN_MASK = {LEN_W{1'b1}};
    localparam int SETTLE_CYCLES = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PLAN_ROWS = 25;

    typedef struct packed {
        mfd_pkg::t_kind kind;
        logic [7:0] payload_byte;
        logic [LEN_W-1:0] frame_length;
        logic [mfd_pkg::TIMESTAMP_W-1:0] timestamp;
        logic [7:0] frame_flags;
        logic last;
        logic [mfd_pkg::RESYNC_W-1:0] resync_total;
    } t_frame_result;

    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_FRAME,
        ROW_CFG
    } t_row_op;

    typedef struct packed {
        t_row_op op;
        logic [7:0] magic_a;
        logic [7:0] magic_b;
        logic [7:0] version;
        logic [7:0] flags;
        logic [mfd_pkg::HDR_LENGTH_W-1:0] length;
        logic [mfd_pkg::TIMESTAMP_W-1:0] stamp;
        logic [mfd_pkg::CFG_INDEX_W-1:0] index;
        logic [mfd_pkg::CFG_DATA_W-1:0] data;
        logic typed;
        t_frame_result result;
    } t_row;

    localparam t_frame_result NO_RESULT = '0;

    logic i_clk;
    logic i_rst_n;

    mfd_byte_if rx_ch();
    mfd_cfg_if cfg_ch();
    mfd_result_if #(.LENGTH_BITS(LEN_W)) res_ch();

    media_frame_deframer_top #(.LENGTH_BITS(LEN_W)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_rx(rx_ch),
        .i_cfg(cfg_ch),
        .o_res(res_ch)
    );

    logic [7:0] cfg_magic_first;
    logic [7:0] cfg_magic_second;
    logic [7:0] cfg_version;
    logic [mfd_pkg::MAX_LENGTH_W-1:0] cfg_max_length;
    logic [7:0] hdr_bytes [mfd_pkg::HDR_BYTES];
    logic [4:0] hdr_fill;
    logic [LEN_W-1:0] bytes_left;
    logic [mfd_pkg::RESYNC_W-1:0] resync_cnt;

    t_frame_result pending_results [$];
    t_row plan [PLAN_ROWS];
    int error_count = 0;
    int item_count;
    int idle_pct;
    int stall_left = 0;
    int quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
    end

    always #2 i_clk = ~i_clk;

    function automatic void count_slip();
        if (resync_cnt != {mfd_pkg::RESYNC_W{1'b1}}) begin
            resync_cnt = resync_cnt + mfd_pkg::RESYNC_W'(1);
        end
    endfunction

    function automatic void deframe_byte(input logic [7:0] rx, output logic produced,
                                         output t_frame_result r);
        logic [mfd_pkg::HDR_LENGTH_W-1:0] hdr_len;
        logic [mfd_pkg::TIMESTAMP_W-1:0] hdr_ts;
        logic [LEN_W-1:0] clipped;
        produced = 1'b0;
        r = '0;
        if (bytes_left != '0) begin
            bytes_left = bytes_left - LEN_W'(1);
            produced = 1'b1;
            r.kind = mfd_pkg::KIND_PAYLOAD;
            r.payload_byte = rx;
            r.last = (bytes_left == '0);
            r.resync_total = resync_cnt;
            return;
        end
        hdr_bytes[hdr_fill[3:0]] = rx;
        hdr_fill = hdr_fill + 5'd1;
        if (hdr_bytes[0] != cfg_magic_first) begin
            hdr_fill = '0;
            count_slip();
            return;
        end
        if (hdr_fill >= 5'd2 && hdr_bytes[1] != cfg_magic_second) begin
            hdr_bytes[0] = hdr_bytes[1];
            hdr_fill = (hdr_bytes[0] == cfg_magic_first) ? 5'd1 : 5'd0;
            count_slip();
            return;
        end
        if (hdr_fill < 5'(mfd_pkg::HDR_BYTES)) begin
            return;
        end
        hdr_fill = '0;
        if (hdr_bytes[2] != cfg_version) begin
            count_slip();
            return;
        end
        hdr_len = {hdr_bytes[7], hdr_bytes[6], hdr_bytes[5], hdr_bytes[4]};
        hdr_ts = {hdr_bytes[15], hdr_bytes[14], hdr_bytes[13], hdr_bytes[12],
                  hdr_bytes[11], hdr_bytes[10], hdr_bytes[9], hdr_bytes[8]};
        clipped = (hdr_len > mfd_pkg::HDR_LENGTH_W'(LEN_MASK)) ? LEN_MASK
                                                               : hdr_len[LEN_W-1:0];
        produced = 1'b1;
        r.frame_length = clipped;
        r.resync_total = resync_cnt;
        if (hdr_len > mfd_pkg::HDR_LENGTH_W'(cfg_max_length)) begin
            r.kind = mfd_pkg::KIND_TOO_LARGE;
            r.last = 1'b1;
        end else begin
            bytes_left = clipped;
            r.kind = mfd_pkg::KIND_HEADER;
            r.timestamp = hdr_ts;
            r.frame_flags = hdr_bytes[3];
            r.last = (clipped == '0);
        end
    endfunction

    function automatic t_frame_result result_of(input mfd_pkg::t_kind kind,
                                                input logic [LEN_W-1:0] len,
                                                input logic [63:0] ts, input logic [7:0] flags,
                                                input logic last, input logic [15:0] resync);
        t_frame_result r;
        r = '0;
        r.kind = kind;
        r.frame_length = len;
        r.timestamp = ts;
        r.frame_flags = flags;
        r.last = last;
        r.resync_total = resync;
        return r;
    endfunction

    function automatic t_row byte_row(input logic [7:0] rx);
        t_row row;
        row = '0;
        row.op = ROW_BYTE;
        row.magic_a = rx;
        return row;
    endfunction

    function automatic t_row cfg_row(input logic [mfd_pkg::CFG_INDEX_W-1:0] index,
                                     input logic [mfd_pkg::CFG_DATA_W-1:0] data);
        t_row row;
        row = '0;
        row.op = ROW_CFG;
        row.index = index;
        row.data = data;
        return row;
    endfunction

    function automatic t_row frame_row(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] ver, input logic [7:0] flags,
                                       input logic [31:0] len, input logic [63:0] ts);
        t_row row;
        row = '0;
        row.op = ROW_FRAME;
        row.magic_a = a;
        row.magic_b = b;
        row.version = ver;
        row.flags = flags;
        row.length = len;
        row.stamp = ts;
        return row;
    endfunction

    function automatic t_row expecting(input t_row row, input t_frame_result want);
        t_row r;
        r = row;
        r.typed = 1'b1;
        r.result = want;
        return r;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return cfg_magic_first;
            1: return cfg_magic_second;
            2: return cfg_version;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == cfg_magic_first) begin
            b = ~b;
        end
        return b;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (error_count < 100) begin
            $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
        end
        error_count++;
    endtask

    task automatic check_result();
        t_frame_result want;
        if (pending_results.size() == 0) begin
            report_mismatch("result with nothing expected, kind", 64'(res_ch.kind), 64'd0);
        end else begin
            want = pending_results.pop_front();
            if (res_ch.kind !== want.kind) begin
                report_mismatch("kind", 64'(res_ch.kind), 64'(want.kind));
            end
            if (res_ch.payload_byte !== want.payload_byte) begin
                report_mismatch("payload_byte", 64'(res_ch.payload_byte),
                                64'(want.payload_byte));
            end
            if (res_ch.frame_length !== want.frame_length) begin
                report_mismatch("frame_length", 64'(res_ch.frame_length),
                                64'(want.frame_length));
            end
            if (res_ch.timestamp !== want.timestamp) begin
                report_mismatch("timestamp", res_ch.timestamp, want.timestamp);
            end
            if (res_ch.frame_flags !== want.frame_flags) begin
                report_mismatch("frame_flags", 64'(res_ch.frame_flags), 64'(want.frame_flags));
            end
            if (res_ch.last !== want.last) begin
                report_mismatch("last", 64'(res_ch.last), 64'(want.last));
            end
            if (res_ch.resync_total !== want.resync_total) begin
                report_mismatch("resync_total", 64'(res_ch.resync_total),
                                64'(want.resync_total));
            end
        end
    endtask

    task automatic drain_results();
        rx_ch.valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_byte(input logic [7:0] rx, input logic typed, input t_frame_result want);
        logic produced;
        t_frame_result r;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            rx_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= rx;
        @(posedge i_clk);
        while (!rx_ch.ready) begin
            @(posedge i_clk);
        end
        deframe_byte(rx, produced, r);
        if (typed) begin
            pending_results.push_back(want);
        end else if (produced) begin
            pending_results.push_back(r);
        end
        item_count++;
    endtask

    task automatic write_reg(input logic [mfd_pkg::CFG_INDEX_W-1:0] index,
                             input logic [mfd_pkg::CFG_DATA_W-1:0] data);
        drain_results();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) begin
            @(posedge i_clk);
        end
        case (index)
            mfd_pkg::REG_MAGIC_FIRST: cfg_magic_first = data[7:0];
            mfd_pkg::REG_MAGIC_SECOND: cfg_magic_second = data[7:0];
            mfd_pkg::REG_FORMAT_VERSION: cfg_version = data[7:0];
            mfd_pkg::REG_MAX_LENGTH: cfg_max_length = data[mfd_pkg::MAX_LENGTH_W-1:0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_frame(input logic [7:0] a, input logic [7:0] b, input logic [7:0] ver,
                              input logic [7:0] flags, input logic [31:0] len,
                              input logic [63:0] ts, input int cut, input logic typed,
                              input t_frame_result want);
        logic [8*mfd_pkg::HDR_BYTES-1:0] hdr;
        hdr = {ts, len, flags, ver, b, a};
        for (int i = 0; i < cut; i++) begin
            push_byte(hdr[8*i +: 8], typed && (i == mfd_pkg::HDR_BYTES - 1), want);
        end
        while (bytes_left != '0) begin
            push_byte(pick_byte(), 1'b0, NO_RESULT);
        end
    endtask

    task automatic flush_hunt();
        while (hdr_fill != '0 || bytes_left != '0) begin
            push_byte((bytes_left != '0) ? pick_byte() : junk_byte(), 1'b0, NO_RESULT);
        end
    endtask

    // Large limits admit only streams that leave the hunt aligned, so that no header
    // assembled from stray bytes can announce a payload of a million bytes.
    task automatic random_frame();
        int pick;
        int cut;
        logic big;
        logic [mfd_pkg::HDR_LENGTH_W-1:0] len;
        logic [7:0] ver;
        big = (cfg_max_length > 64);
        pick = $urandom_range(0, 99);
        cut = mfd_pkg::HDR_BYTES;
        ver = cfg_version;
        if (pick < 3) begin
            drain_results();
        end
        if (pick < 12) begin
            repeat ($urandom_range(1, 6)) begin
                push_byte(big ? junk_byte() : pick_byte(), 1'b0, NO_RESULT);
            end
        end else begin
            len = $urandom_range(0, big ? 40 : int'(cfg_max_length));
            if (pick < 20) begin
                len = mfd_pkg::HDR_LENGTH_W'(cfg_max_length) + 1 + $urandom_range(0, 3);
            end else if (pick < 27) begin
                len = $urandom;
                if (len <= mfd_pkg::HDR_LENGTH_W'(cfg_max_length)) begin
                    len = '1;
                end
            end else if (pick < 35) begin
                ver = cfg_version ^ (8'd1 << $urandom_range(0, 7));
            end else if (pick < 43 && !big) begin
                cut = $urandom_range(1, mfd_pkg::HDR_BYTES - 1);
            end
            send_frame(cfg_magic_first, cfg_magic_second, ver, 8'($urandom), len,
                       {$urandom, $urandom}, cut, 1'b0, NO_RESULT);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid === 1'b1 && res_ch.ready) begin
            check_result();
        end
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            res_ch.ready <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            stall_left <= $urandom_range(0, 15);
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((rx_ch.valid && rx_ch.ready) || (cfg_ch.valid && cfg_ch.ready)
                || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [mfd_pkg::CFG_DATA_W-1:0] max_pick;
        cfg_magic_first = '0;
        cfg_magic_second = '0;
        cfg_version = '0;
        cfg_max_length = mfd_pkg::MAX_LENGTH_RESET;
        foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
        hdr_fill = '0;
        bytes_left = '0;
        resync_cnt = '0;
        item_count = 0;
        idle_pct = 0;

        i_rst_n <= 1'b0;
        rx_ch.valid <= 1'b0;
        rx_ch.rx_byte <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data <= '0;

        plan[0] = byte_row(8'hFF);
        plan[1] = expecting(frame_row(8'h00, 8'h00, 8'h00, 8'hFF, 32'd0, '1),
                            result_of(mfd_pkg::KIND_HEADER, '0, '1, 8'hFF, 1'b1, 16'd1));
        plan[2] = cfg_row(mfd_pkg::REG_MAGIC_FIRST, 21'h1FFFA5);
        plan[3] = cfg_row(mfd_pkg::REG_MAGIC_SECOND, 21'h00005A);
        plan[4] = cfg_row(mfd_pkg::REG_FORMAT_VERSION, 21'h000001);
        plan[5] = cfg_row('1, 21'h1FFFFF);
        plan[6] = cfg_row(mfd_pkg::REG_MAX_LENGTH, 21'd3);
        plan[7] = expecting(frame_row(8'hA5, 8'h5A, 8'h01, 8'h00, 32'd3, '0),
                            result_of(mfd_pkg::KIND_HEADER, 21'd3, '0, 8'h00, 1'b0, 16'd1));
        plan[8] = expecting(frame_row(8'hA5, 8'h5A, 8'h01, 8'h3C, 32'd4, 64'h0123456789ABCDEF),
                            result_of(mfd_pkg::KIND_TOO_LARGE, 21'd4, '0, 8'h00, 1'b1, 16'd1));
        plan[9] = frame_row(8'hA5, 8'h5A, 8'h02, 8'h00, 32'd0, '0);
        plan[10] = byte_row(8'hA5);
        plan[11] = byte_row(8'hA5);
        plan[12] = byte_row(8'h00);
        plan[13] = frame_row(8'hA5, 8'h5A, 8'h01, 8'h81, 32'd2, 64'h8000000000000001);
        plan[14] = byte_row(8'hA5);
        plan[15] = byte_row(8'h5A);
        plan[16] = cfg_row(mfd_pkg::REG_MAGIC_FIRST, 21'h000077);
        plan[17] = byte_row(8'h01);
        plan[18] = cfg_row(mfd_pkg::REG_MAGIC_FIRST, 21'h0000A5);
        plan[19] = cfg_row(mfd_pkg::REG_MAX_LENGTH, 21'h1FFFFF);
        plan[20] = expecting(frame_row(8'hA5, 8'h5A, 8'h01, 8'h00, 32'hFFFFFFFF, '0),
                             result_of(mfd_pkg::KIND_TOO_LARGE, LEN_MASK, '0, 8'h00, 1'b1,
                                       16'd5));
        plan[21] = cfg_row(mfd_pkg::REG_MAX_LENGTH, 21'd0);
        plan[22] = expecting(frame_row(8'hA5, 8'h5A, 8'h01, 8'h00, 32'd0, 64'd5),
                             result_of(mfd_pkg::KIND_HEADER, '0, 64'd5, 8'h00, 1'b1, 16'd5));
        plan[23] = expecting(frame_row(8'hA5, 8'h5A, 8'h01, 8'h00, 32'd1, '0),
                             result_of(mfd_pkg::KIND_TOO_LARGE, 21'd1, '0, 8'h00, 1'b1,
                                       16'd5));
        plan[24] = expecting(frame_row(8'hA5, 8'h5A, 8'h01, 8'h00, 32'h00200000, '0),
                             result_of(mfd_pkg::KIND_TOO_LARGE, LEN_MASK, '0, 8'h00, 1'b1,
                                       16'd5));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < PLAN_ROWS; i++) begin
            case (plan[i].op)
                ROW_BYTE: push_byte(plan[i].magic_a, plan[i].typed, plan[i].result);
                ROW_CFG: write_reg(plan[i].index, plan[i].data);
                default: send_frame(plan[i].magic_a, plan[i].magic_b, plan[i].version,
                                    plan[i].flags, plan[i].length, plan[i].stamp,
                                    mfd_pkg::HDR_BYTES, plan[i].typed, plan[i].result);
            endcase
        end

        while (item_count < 250) begin
            idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 12;
            write_reg(mfd_pkg::REG_MAGIC_FIRST, mfd_pkg::CFG_DATA_W'($urandom));
            write_reg(mfd_pkg::REG_MAGIC_SECOND, mfd_pkg::CFG_DATA_W'($urandom));
            write_reg(mfd_pkg::REG_FORMAT_VERSION, mfd_pkg::CFG_DATA_W'($urandom));
            case ($urandom_range(0, 9))
                0: max_pick = '0;
                1: max_pick = 21'h100000;
                2: max_pick = 21'h1FFFFF;
                default: max_pick = mfd_pkg::CFG_DATA_W'($urandom_range(1, 40));
            endcase
            write_reg(mfd_pkg::REG_MAX_LENGTH, max_pick);
            repeat ($urandom_range(3, 8)) random_frame();
            flush_hunt();
        end

        // The closing stretch runs without idling.
        idle_pct = 0;
        write_reg(mfd_pkg::REG_MAGIC_FIRST, mfd_pkg::CFG_DATA_W'($urandom));
        write_reg(mfd_pkg::REG_MAX_LENGTH, 21'd24);
        repeat (24) push_byte(junk_byte(), 1'b0, NO_RESULT);
        repeat (6) random_frame();
        flush_hunt();

        drain_results();
        repeat (8) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch("results never received", 64'(pending_results.size()), 64'd0);
        end
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/mfd_pkg.sv
sv/mfd_if.sv
sv/mfd_cfg_regs.sv
sv/mfd_in_stage.sv
sv/mfd_hunt.sv
sv/mfd_out_stage.sv
sv/media_frame_deframer_top.sv
sv/mfd_checker.sv
tb/tb_top.sv
